// ===== design/eaq_pkg.sv =====
// ----------------------------------------------------------------------------
// eaq_pkg
// shared types and constants of the euler angle to quaternion converter
// ----------------------------------------------------------------------------
package eaq_pkg;

    // cordic datapath widths: x and y in Q30 with headroom, z in pi = 2^31 units
    localparam int EAQ_XY_W   = 33;
    localparam int EAQ_Z_W    = 34;
    localparam int EAQ_TRIG_W = 32;
    localparam int EAQ_ATAN_N = 32;

    // round(2^30 / K) with K the infinite-stage cordic gain
    localparam logic signed [EAQ_XY_W-1:0] EAQ_INV_GAIN = 33'sd652032874;

    typedef logic [31:0] t_atan_tab [EAQ_ATAN_N];

    // round(atan(2^-i) / pi * 2^31)
    localparam t_atan_tab EAQ_ATAN = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // cosine and sine of one half angle, Q30
    typedef struct packed {
        logic signed [EAQ_TRIG_W-1:0] cos_q30;
        logic signed [EAQ_TRIG_W-1:0] sin_q30;
    } t_trig;

endpackage

// ===== design/eaq_cordic.sv =====
// ----------------------------------------------------------------------------
// eaq_cordic
// pipelined rotation-mode cordic: sine and cosine of half a binary angle
// ----------------------------------------------------------------------------
module eaq_cordic #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [ANGLE_BITS-1:0] i_angle,
    output eaq_pkg::t_trig               o_trig
);

    localparam int XY_W = eaq_pkg::EAQ_XY_W;
    localparam int Z_W  = eaq_pkg::EAQ_Z_W;
    localparam int ZSH  = 32 - ANGLE_BITS;

    logic signed [XY_W-1:0] r_x [CORDIC_STAGES];
    logic signed [XY_W-1:0] r_y [CORDIC_STAGES];
    logic signed [Z_W-1:0]  r_z [CORDIC_STAGES];

    logic signed [Z_W-1:0] w_a_ext;
    logic signed [Z_W-1:0] w_z0;

    // halve, then scale to pi = 2^31 units
    assign w_a_ext = {{(Z_W-ANGLE_BITS){i_angle[ANGLE_BITS-1]}}, i_angle};
    assign w_z0    = (w_a_ext >>> 1) <<< ZSH;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        logic signed [XY_W-1:0] w_xi;
        logic signed [XY_W-1:0] w_yi;
        logic signed [Z_W-1:0]  w_zi;
        logic signed [XY_W-1:0] n_x;
        logic signed [XY_W-1:0] n_y;
        logic signed [Z_W-1:0]  n_z;
        logic signed [Z_W-1:0]  w_atan;

        if (g == 0) begin : g_first
            assign w_xi = eaq_pkg::EAQ_INV_GAIN;
            assign w_yi = '0;
            assign w_zi = w_z0;
        end else begin : g_next
            assign w_xi = r_x[g-1];
            assign w_yi = r_y[g-1];
            assign w_zi = r_z[g-1];
        end

        assign w_atan = {{(Z_W-32){1'b0}}, eaq_pkg::EAQ_ATAN[g]};

        always_comb begin
            if (!w_zi[Z_W-1]) begin
                n_x = w_xi - (w_yi >>> g);
                n_y = w_yi + (w_xi >>> g);
                n_z = w_zi - w_atan;
            end else begin
                n_x = w_xi + (w_yi >>> g);
                n_y = w_yi - (w_xi >>> g);
                n_z = w_zi + w_atan;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g] <= n_x;
                r_y[g] <= n_y;
                r_z[g] <= n_z;
            end
        end
    end

    assign o_trig.cos_q30 = r_x[CORDIC_STAGES-1][eaq_pkg::EAQ_TRIG_W-1:0];
    assign o_trig.sin_q30 = r_y[CORDIC_STAGES-1][eaq_pkg::EAQ_TRIG_W-1:0];

endmodule

// ===== design/euler_angles_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion
// yaw-pitch-roll angles to scalar-first quaternion, saturated fixed point
// ----------------------------------------------------------------------------
// The block takes one item (roll, pitch, yaw as signed binary angles, full
// scale plus or minus pi) per clock and delivers one quaternion item per item,
// in order. The pipeline has one register per cordic iteration, two multiplier
// stages for the triple products, one stage for the sums and one for rounding
// and saturation. Throughput is one item per cycle; while a result is stalled
// at the output the whole pipeline holds and o_stall is raised.
module euler_angles_to_quaternion #(
    parameter int ANGLE_BITS    = 16,
    parameter int QUAT_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [ANGLE_BITS-1:0] i_roll_angle,
    input  logic signed [ANGLE_BITS-1:0] i_pitch_angle,
    input  logic signed [ANGLE_BITS-1:0] i_yaw_angle,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [QUAT_BITS-1:0]  o_quat_scalar,
    output logic signed [QUAT_BITS-1:0]  o_quat_x,
    output logic signed [QUAT_BITS-1:0]  o_quat_y,
    output logic signed [QUAT_BITS-1:0]  o_quat_z
);

    localparam int TW     = eaq_pkg::EAQ_TRIG_W;
    localparam int LAT    = CORDIC_STAGES + 4;
    localparam int RND_SH = (QUAT_BITS < 31) ? (31 - QUAT_BITS) : 0;
    localparam logic signed [33:0] RND  = 34'((64'sd1 <<< RND_SH) >>> 1);
    localparam logic signed [33:0] Q_HI = 34'((64'sd1 <<< (QUAT_BITS - 1)) - 64'sd1);
    localparam logic signed [33:0] Q_LO = -Q_HI - 34'sd1;

    function automatic logic signed [TW-1:0] mul_q30(input logic signed [TW-1:0] a,
                                                      input logic signed [TW-1:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return p[61:30];
    endfunction

    function automatic logic signed [QUAT_BITS-1:0] sat_out(input logic signed [32:0] v);
        logic signed [33:0] t;
        t = ($signed({v[32], v}) + RND) >>> RND_SH;
        if (t > Q_HI) begin
            t = Q_HI;
        end else if (t < Q_LO) begin
            t = Q_LO;
        end
        return t[QUAT_BITS-1:0];
    endfunction

    logic           w_en;
    logic [LAT-1:0] r_vld;
    eaq_pkg::t_trig w_roll;
    eaq_pkg::t_trig w_pitch;
    eaq_pkg::t_trig w_yaw;

    // pipeline advances unless the result at the output is held
    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    eaq_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_roll_angle),
        .o_trig (w_roll)
    );

    eaq_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_pitch_angle),
        .o_trig (w_pitch)
    );

    eaq_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_yaw_angle),
        .o_trig (w_yaw)
    );

    // roll-pitch pair products, yaw carried along
    logic signed [TW-1:0] r_crcp, r_srsp, r_srcp, r_crsp, r_cy, r_sy;
    // triple products
    logic signed [TW-1:0] r_t_ccc, r_t_sss, r_t_scc, r_t_css;
    logic signed [TW-1:0] r_t_csc, r_t_scs, r_t_ccs, r_t_ssc;
    // component sums, Q30
    logic signed [32:0] r_s_w, r_s_x, r_s_y, r_s_z;
    logic signed [QUAT_BITS-1:0] r_q_w, r_q_x, r_q_y, r_q_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_crcp  <= mul_q30(w_roll.cos_q30, w_pitch.cos_q30);
            r_srsp  <= mul_q30(w_roll.sin_q30, w_pitch.sin_q30);
            r_srcp  <= mul_q30(w_roll.sin_q30, w_pitch.cos_q30);
            r_crsp  <= mul_q30(w_roll.cos_q30, w_pitch.sin_q30);
            r_cy    <= w_yaw.cos_q30;
            r_sy    <= w_yaw.sin_q30;

            r_t_ccc <= mul_q30(r_crcp, r_cy);
            r_t_sss <= mul_q30(r_srsp, r_sy);
            r_t_scc <= mul_q30(r_srcp, r_cy);
            r_t_css <= mul_q30(r_crsp, r_sy);
            r_t_csc <= mul_q30(r_crsp, r_cy);
            r_t_scs <= mul_q30(r_srcp, r_sy);
            r_t_ccs <= mul_q30(r_crcp, r_sy);
            r_t_ssc <= mul_q30(r_srsp, r_cy);

            r_s_w   <= {r_t_ccc[TW-1], r_t_ccc} + {r_t_sss[TW-1], r_t_sss};
            r_s_x   <= {r_t_scc[TW-1], r_t_scc} - {r_t_css[TW-1], r_t_css};
            r_s_y   <= {r_t_csc[TW-1], r_t_csc} + {r_t_scs[TW-1], r_t_scs};
            r_s_z   <= {r_t_ccs[TW-1], r_t_ccs} - {r_t_ssc[TW-1], r_t_ssc};

            r_q_w   <= sat_out(r_s_w);
            r_q_x   <= sat_out(r_s_x);
            r_q_y   <= sat_out(r_s_y);
            r_q_z   <= sat_out(r_s_z);
        end
    end

    assign o_quat_scalar = r_q_w;
    assign o_quat_x      = r_q_x;
    assign o_quat_y      = r_q_y;
    assign o_quat_z      = r_q_z;

    a_stall_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

// ===== tb/eaq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eaq_checker
// watches both channels of the euler angle to quaternion converter, predicts
// each quaternion from the accepted angles and compares results in order
// ----------------------------------------------------------------------------
module eaq_checker #(
    parameter int ANGLE_BITS    = 16,
    parameter int QUAT_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic signed [ANGLE_BITS-1:0] i_roll,
    input  logic signed [ANGLE_BITS-1:0] i_pitch,
    input  logic signed [ANGLE_BITS-1:0] i_yaw,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic signed [QUAT_BITS-1:0]  i_quat_scalar,
    input  logic signed [QUAT_BITS-1:0]  i_quat_x,
    input  logic signed [QUAT_BITS-1:0]  i_quat_y,
    input  logic signed [QUAT_BITS-1:0]  i_quat_z,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_result_count
);

    localparam longint INV_GAIN_Q30 = 64'sd652032874;
    localparam longint ROUND_Q30    = 64'sd536870912;

    // atan(2^-i) in units of pi = 2^31
    localparam logic [31:0] ATAN_Q31 [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [QUAT_BITS-1:0] scalar;
        logic signed [QUAT_BITS-1:0] x;
        logic signed [QUAT_BITS-1:0] y;
        logic signed [QUAT_BITS-1:0] z;
    } t_quat;

    t_quat quat_expect_q [$];
    int    fail_count   = 0;
    int    result_count = 0;

    assign o_fail_count   = fail_count;
    assign o_result_count = result_count;

    initial o_pending = 0;

    // cosine and sine of half the angle, both Q30
    function automatic void half_angle_trig(input longint ang, output longint c,
                                            output longint s);
        longint z, x, y, dx, dy;
        z = (ang >>> 1) * (longint'(1) << (32 - ANGLE_BITS));
        x = INV_GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_Q31[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_Q31[i]);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b + ROUND_Q30) >>> 30;
    endfunction

    function automatic longint q30_triple(input longint a, input longint b,
                                          input longint c);
        return q30_mul(q30_mul(a, b), c);
    endfunction

    function automatic logic signed [QUAT_BITS-1:0] round_sat(input longint v);
        longint hi, lo, r;
        int     sh;
        sh = 31 - QUAT_BITS;
        hi = (longint'(1) << (QUAT_BITS - 1)) - 1;
        lo = -hi - 1;
        r  = v;
        if (sh > 0) begin
            r = (v + (longint'(1) << (sh - 1))) >>> sh;
        end
        if (r > hi) begin
            r = hi;
        end
        if (r < lo) begin
            r = lo;
        end
        return r[QUAT_BITS-1:0];
    endfunction

    function automatic t_quat predict_quaternion(input longint roll, input longint pitch,
                                                 input longint yaw);
        longint cr, sr, cp, sp, cy, sy;
        t_quat  q;
        half_angle_trig(roll, cr, sr);
        half_angle_trig(pitch, cp, sp);
        half_angle_trig(yaw, cy, sy);
        q.scalar = round_sat(q30_triple(cr, cp, cy) + q30_triple(sr, sp, sy));
        q.x      = round_sat(q30_triple(sr, cp, cy) - q30_triple(cr, sp, sy));
        q.y      = round_sat(q30_triple(cr, sp, cy) + q30_triple(sr, cp, sy));
        q.z      = round_sat(q30_triple(cr, cp, sy) - q30_triple(sr, sp, cy));
        return q;
    endfunction

    always @(posedge i_clk) begin : watch
        t_quat want;
        t_quat got;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                quat_expect_q.push_back(predict_quaternion(i_roll, i_pitch, i_yaw));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_quat_scalar, i_quat_x, i_quat_y, i_quat_z};
                result_count++;
                if (quat_expect_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected result w=%0d x=%0d y=%0d z=%0d",
                                 got.scalar, got.x, got.y, got.z);
                    end
                    fail_count++;
                end else begin
                    want = quat_expect_q.pop_front();
                    if (got.scalar !== want.scalar || got.x !== want.x ||
                        got.y !== want.y || got.z !== want.z) begin
                        if (fail_count < 10) begin
                            $display("mismatch at result %0d: expected w=%0d x=%0d y=%0d z=%0d",
                                     result_count, want.scalar, want.x, want.y, want.z);
                            $display("                      actual   w=%0d x=%0d y=%0d z=%0d",
                                     got.scalar, got.x, got.y, got.z);
                        end
                        fail_count++;
                    end
                end
            end
            o_pending <= quat_expect_q.size();
        end
    end

endmodule

// ===== tb/tb_euler_angles_to_quaternion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_angles_to_quaternion
// drives roll, pitch and yaw items into the converter under varying idle and
// stall mixes, with two long output hold-offs; a checker beside the block
// predicts every quaternion and compares it against the block's output
// ----------------------------------------------------------------------------
module tb_euler_angles_to_quaternion;

    localparam int ANGLE_BITS    = 16;
    localparam int QUAT_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = CORDIC_STAGES + 12;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         in_valid   = 1'b0;
    logic                         in_stall;
    logic signed [ANGLE_BITS-1:0] roll       = '0;
    logic signed [ANGLE_BITS-1:0] pitch      = '0;
    logic signed [ANGLE_BITS-1:0] yaw        = '0;
    logic                         out_valid;
    logic                         out_stall  = 1'b0;
    logic signed [QUAT_BITS-1:0]  quat_w;
    logic signed [QUAT_BITS-1:0]  quat_x;
    logic signed [QUAT_BITS-1:0]  quat_y;
    logic signed [QUAT_BITS-1:0]  quat_z;

    int fail_count;
    int pending;
    int result_count;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_cnt      = 0;
    int item_count    = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    euler_angles_to_quaternion #(
        .ANGLE_BITS   (ANGLE_BITS),
        .QUAT_BITS    (QUAT_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_roll_angle (roll),
        .i_pitch_angle(pitch),
        .i_yaw_angle  (yaw),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_quat_scalar(quat_w),
        .o_quat_x     (quat_x),
        .o_quat_y     (quat_y),
        .o_quat_z     (quat_z)
    );

    eaq_checker #(
        .ANGLE_BITS   (ANGLE_BITS),
        .QUAT_BITS    (QUAT_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_roll        (roll),
        .i_pitch       (pitch),
        .i_yaw         (yaw),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_quat_scalar (quat_w),
        .i_quat_x      (quat_x),
        .i_quat_y      (quat_y),
        .i_quat_z      (quat_z),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count)
    );

    // output side: random stall, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_ack != hold_req) begin
            out_stall <= 1'b1;
            hold_cnt++;
            if (hold_cnt == HOLD_CYCLES) begin
                hold_cnt = 0;
                hold_ack = hold_req;
            end
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_item(input logic signed [ANGLE_BITS-1:0] r,
                             input logic signed [ANGLE_BITS-1:0] p,
                             input logic signed [ANGLE_BITS-1:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        roll     <= r;
        pitch    <= p;
        yaw      <= y;
        do @(posedge clk); while (in_stall);
        item_count++;
    endtask

    // stop offering and wait until every expected quaternion has come out
    task automatic drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic signed [ANGLE_BITS-1:0] pick_angle;
        logic signed [ANGLE_BITS-1:0] corner [6];
        corner = '{16'sh8000, 16'sh7fff, 16'shc000, 16'sh4000, 16'sh0000, 16'shffff};
        case ($urandom_range(3))
            0, 1:    return ANGLE_BITS'($urandom);
            2:       return ANGLE_BITS'($urandom_range(512) - 256);
            default: return corner[$urandom_range(5)];
        endcase
    endfunction

    task automatic random_phase(input int n, input int sidle, input int ridle,
                                input int hold_at);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int k = 0; k < n; k++) begin
            if (k == hold_at) begin
                hold_req++;
            end
            send_item(pick_angle(), pick_angle(), pick_angle());
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 55;
        // zero rotation, where the scalar part sits at +1.0 and saturates
        send_item(16'sh0000, 16'sh0000, 16'sh0000);
        // each angle alone at -pi, +pi minus one code and +pi/2 or -pi/2, then all at +/- one code
        send_item(16'sh8000, 16'sh0000, 16'sh0000);
        send_item(16'sh0000, 16'sh8000, 16'sh0000);
        send_item(16'sh0000, 16'sh0000, 16'sh8000);
        send_item(16'sh7fff, 16'sh0000, 16'sh0000);
        send_item(16'sh0000, 16'sh7fff, 16'sh0000);
        send_item(16'sh0000, 16'sh0000, 16'sh7fff);
        send_item(16'sh4000, 16'sh0000, 16'sh0000);
        send_item(16'sh0000, 16'shc000, 16'sh0000);
        send_item(16'sh0000, 16'sh0000, 16'sh4000);
        send_item(16'sh0001, 16'shffff, 16'sh0001);
        send_item(16'shffff, 16'sh0001, 16'shffff);
        // all three together at the extremes, at +/- pi/2 and at mixed values
        send_item(16'sh8000, 16'sh8000, 16'sh8000);
        send_item(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(16'sh8000, 16'sh7fff, 16'sh8000);
        send_item(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_item(16'sh4000, 16'sh4000, 16'sh4000);
        send_item(16'shc000, 16'shc000, 16'shc000);
        send_item(16'sh5555, 16'shaaaa, 16'sh5555);
        send_item(16'shaaaa, 16'sh5555, 16'shaaaa);
        drain();

        random_phase(210, 27, 55, 60);
        random_phase(210, 55, 27, -1);
        random_phase(230, 0, 0, 100);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d angle items and %0d quaternion results under three idle mixes",
                 item_count, result_count);
        $display("with two long output hold-offs, -pi and +pi corners and saturation at +1.0");
        if (fail_count == 0 && pending == 0) begin
            $display("tb_euler_angles_to_quaternion: PASS");
        end else begin
            $display("tb_euler_angles_to_quaternion: FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb_euler_angles_to_quaternion: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/eaq_pkg.sv
design/eaq_cordic.sv
design/euler_angles_to_quaternion.sv
tb/eaq_checker.sv
tb/tb_euler_angles_to_quaternion.sv
